/* src/ptrt_pkg.sv */
// Package for the periodic task release table: entry and result types,
// request and result codes, and sizing constants. No dependencies.
package ptrt_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int RES_W         = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] A_ADD    = 2'd0;
    localparam logic [1:0] A_REMOVE = 2'd1;
    localparam logic [1:0] A_TICK   = 2'd2;

    localparam logic [1:0] K_ADD     = 2'd0;
    localparam logic [1:0] K_REMOVE  = 2'd1;
    localparam logic [1:0] K_RELEASE = 2'd2;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] period;
        logic [15:0] remaining;
        logic [7:0]  prio;
    } t_entry;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] task_id;
        logic       ok;
        logic       last;
    } t_result;

endpackage

/* src/ptrt_mem.sv */
// Task table storage: one write port, one registered read port.
// Depends on ptrt_pkg for the entry type.
module ptrt_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  ptrt_pkg::t_entry i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output ptrt_pkg::t_entry o_rdata
);
    import ptrt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/ptrt_out.sv */
// Output register for result requests; frees itself as the sink takes them.
// Depends on ptrt_pkg for the result type.
module ptrt_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ptrt_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output ptrt_pkg::t_result o_res
);
    import ptrt_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* src/ptrt_ctrl.sv */
// Sequencer: add (ordered insert), remove (delete and close gap) and tick walk over
// the table, one entry per cycle unless a release waits on output. Depends on ptrt_pkg.
module ptrt_ctrl #(
    parameter int MAX_TASKS = ptrt_pkg::MAX_TASKS_DEF,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_task_id,
    input  logic [15:0]       i_period,
    input  logic [7:0]        i_priority_req,
    output logic              o_we,
    output logic [IDX_W-1:0]  o_waddr,
    output ptrt_pkg::t_entry  o_wdata,
    output logic              o_re,
    output logic [IDX_W-1:0]  o_raddr,
    input  ptrt_pkg::t_entry  i_rdata,
    input  logic              i_out_free,
    output logic              o_push,
    output ptrt_pkg::t_result o_res
);
    import ptrt_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD_CHK  = 3'd1;
    localparam logic [2:0] S_ADD_PUT  = 3'd2;
    localparam logic [2:0] S_RM_FIND  = 3'd3;
    localparam logic [2:0] S_RM_SHIFT = 3'd4;
    localparam logic [2:0] S_TK_WALK  = 3'd5;
    localparam logic [2:0] S_TK_END   = 3'd6;
    localparam logic [2:0] S_RESP     = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0]       r_act, n_act;
    logic [7:0]       r_id, n_id;
    logic [15:0]      r_per, n_per;
    logic [7:0]       r_prio, n_prio;
    logic             r_ok, n_ok;
    logic [RES_W-1:0] r_n, n_n;
    logic             r_pend_v, n_pend_v;
    logic [7:0]       r_pend_id, n_pend_id;

    logic   at_end;
    logic   rel;
    logic   rec;
    t_entry new_ent;

    assign at_end  = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign rel     = i_rdata.remaining == 16'd0;
    assign rec     = rel && (r_n < RES_W'(MAX_RESULTS));
    assign new_ent = '{id: r_id, period: r_per, remaining: r_per, prio: r_prio};
    assign o_stall = r_state != S_IDLE;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_act     = r_act;
        n_id      = r_id;
        n_per     = r_per;
        n_prio    = r_prio;
        n_ok      = r_ok;
        n_n       = r_n;
        n_pend_v  = r_pend_v;
        n_pend_id = r_pend_id;
        o_we      = 1'b0;
        o_waddr   = r_idx;
        o_wdata   = i_rdata;
        o_re      = 1'b0;
        o_raddr   = r_idx + IDX_W'(1);
        o_push    = 1'b0;
        o_res     = '{kind: K_RELEASE, task_id: r_pend_id, ok: 1'b1, last: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act  = i_action;
                    n_id   = i_task_id;
                    n_per  = i_period;
                    n_prio = i_priority_req;
                    case (i_action)
                        A_ADD: begin
                            if (r_count >= CNT_W'(MAX_TASKS)) begin
                                n_ok    = 1'b0;
                                n_state = S_RESP;
                            end else if (r_count == '0) begin
                                o_we    = 1'b1;
                                o_waddr = '0;
                                o_wdata = '{id: i_task_id, period: i_period,
                                            remaining: i_period, prio: i_priority_req};
                                n_count = r_count + CNT_W'(1);
                                n_ok    = 1'b1;
                                n_state = S_RESP;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = IDX_W'(r_count - CNT_W'(1));
                                n_idx   = IDX_W'(r_count - CNT_W'(1));
                                n_state = S_ADD_CHK;
                            end
                        end
                        A_REMOVE: begin
                            if (r_count == '0) begin
                                n_ok    = 1'b0;
                                n_state = S_RESP;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = '0;
                                n_idx   = '0;
                                n_state = S_RM_FIND;
                            end
                        end
                        A_TICK: begin
                            n_n      = '0;
                            n_pend_v = 1'b0;
                            if (r_count != '0) begin
                                o_re    = 1'b1;
                                o_raddr = '0;
                                n_idx   = '0;
                                n_state = S_TK_WALK;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_CHK: begin
                o_we    = 1'b1;
                o_waddr = r_idx + IDX_W'(1);
                if (i_rdata.prio > r_prio) begin
                    o_wdata = i_rdata;
                    if (r_idx == '0) begin
                        n_state = S_ADD_PUT;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = r_idx - IDX_W'(1);
                        n_idx   = r_idx - IDX_W'(1);
                    end
                end else begin
                    o_wdata = new_ent;
                    n_count = r_count + CNT_W'(1);
                    n_ok    = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_ADD_PUT: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = new_ent;
                n_count = r_count + CNT_W'(1);
                n_ok    = 1'b1;
                n_state = S_RESP;
            end
            S_RM_FIND: begin
                if (i_rdata.id == r_id) begin
                    if (!at_end) begin
                        o_re    = 1'b1;
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RM_SHIFT;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        n_ok    = 1'b1;
                        n_state = S_RESP;
                    end
                end else if (!at_end) begin
                    o_re  = 1'b1;
                    n_idx = r_idx + IDX_W'(1);
                end else begin
                    n_ok    = 1'b0;
                    n_state = S_RESP;
                end
            end
            S_RM_SHIFT: begin
                o_we    = 1'b1;
                o_waddr = r_idx - IDX_W'(1);
                o_wdata = i_rdata;
                if (!at_end) begin
                    o_re  = 1'b1;
                    n_idx = r_idx + IDX_W'(1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_ok    = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_TK_WALK: begin
                if (!(rec && r_pend_v && !i_out_free)) begin
                    o_we    = 1'b1;
                    o_wdata = i_rdata;
                    o_wdata.remaining = rel ? i_rdata.period
                                            : i_rdata.remaining - 16'd1;
                    if (rec) begin
                        o_push    = r_pend_v;
                        n_pend_v  = 1'b1;
                        n_pend_id = i_rdata.id;
                        n_n       = r_n + RES_W'(1);
                    end
                    if (!at_end) begin
                        o_re  = 1'b1;
                        n_idx = r_idx + IDX_W'(1);
                    end else begin
                        n_state = S_TK_END;
                    end
                end
            end
            S_TK_END: begin
                o_res.last = 1'b1;
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_push   = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_RESP: begin
                o_res = '{kind: (r_act == A_ADD) ? K_ADD : K_REMOVE,
                          task_id: r_id, ok: r_ok, last: 1'b1};
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_n      <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
            r_n      <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_act     <= n_act;
        r_id      <= n_id;
        r_per     <= n_per;
        r_prio    <= n_prio;
        r_ok      <= n_ok;
        r_pend_id <= n_pend_id;
    end

endmodule

/* src/periodic_task_release_table.sv */
// Periodic task release table, top level: sequencer, table memory, output register.
// The single read and write port of the table paces each walk at one entry a cycle,
// except where a tick release waits for room in the output register.
// One request at a time; a new request is taken when the last walk ends, while
// the final result may still sit in the output register.
// Reset clears the task count and control state; the table memory is not cleared.
module periodic_task_release_table #(
    parameter int MAX_TASKS = ptrt_pkg::MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_task_id,
    input  logic [15:0] i_period,
    input  logic [7:0]  i_priority_req,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_task_id_res,
    output logic        o_ok,
    output logic        o_last
);
    import ptrt_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    logic             we;
    logic [IDX_W-1:0] waddr;
    t_entry           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
    t_entry           rdata;
    logic             out_free;
    logic             push;
    t_result          push_res;
    t_result          out_res;

    ptrt_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_task_id      (i_task_id),
        .i_period       (i_period),
        .i_priority_req (i_priority_req),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_re           (re),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .i_out_free     (out_free),
        .o_push         (push),
        .o_res          (push_res)
    );

    ptrt_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ptrt_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (push_res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res)
    );

    assign o_kind        = out_res.kind;
    assign o_task_id_res = out_res.task_id;
    assign o_ok          = out_res.ok;
    assign o_last        = out_res.last;

endmodule
